// ===== rtl/core/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants of the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int COORD_W     = 15;
   localparam int SIZE_W      = 14;
   localparam int LABEL_W     = 7;
   localparam int THR_W       = 9;
   localparam int SLOT_W      = 7;
   localparam int AREA_W      = 2 * SIZE_W;
   localparam int UNION_W     = AREA_W + 1;
   localparam int PROD_W      = THR_W + UNION_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = THR_W;

   localparam logic [THR_W-1:0] THR_RESET = 9'd115;

   localparam logic [CSR_INDEX_W-1:0] CSR_IOU_THRESHOLD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_AGNOSTIC = 1'd1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]         size_type;
   typedef logic [LABEL_W-1:0]        label_type;
   typedef logic [AREA_W-1:0]         area_type;
   typedef logic [THR_W-1:0]          thr_type;
   typedef logic [SLOT_W-1:0]         slot_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      size_type  width;
      size_type  height;
      label_type label;
   } kept_entry_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } iou_status_type;

endpackage

// ===== rtl/core/gbs_req_if.sv =====
// ----------------------------------------------------------------------------
// gbs_req_if
// Box request channel: valid, ready and one box.
// ----------------------------------------------------------------------------
interface gbs_req_if
   import gbs_pkg::*;
();
   logic      valid;
   logic      ready;
   logic      first_of_set;
   coord_type box_left;
   coord_type box_top;
   size_type  box_width;
   size_type  box_height;
   label_type class_label;

   modport source (
      output valid, first_of_set, box_left, box_top, box_width, box_height, class_label,
      input  ready
   );
   modport sink (
      input  valid, first_of_set, box_left, box_top, box_width, box_height, class_label,
      output ready
   );
endinterface

// ===== rtl/core/gbs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gbs_rsp_if
// Verdict channel: valid, ready and one suppression result.
// ----------------------------------------------------------------------------
interface gbs_rsp_if
   import gbs_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     keep;
   slot_type kept_slot;
   logic     store_full;

   modport source (
      output valid, keep, kept_slot, store_full,
      input  ready
   );
   modport sink (
      input  valid, keep, kept_slot, store_full,
      output ready
   );
endinterface

// ===== rtl/core/gbs_ram.sv =====
// ----------------------------------------------------------------------------
// gbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gbs_iou.sv =====
// ----------------------------------------------------------------------------
// gbs_iou
// Pipelined overlap test of the current box against one kept box per cycle.
// ----------------------------------------------------------------------------
module gbs_iou
   import gbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           rd_valid,
   input  kept_entry_type rd_entry,
   input  kept_entry_type cur,
   input  area_type       area_a,
   input  thr_type        thr,
   input  logic           agnostic,
   output iou_status_type status
);

   function automatic size_type overlap_1d(coord_type a0, size_type alen,
                                           coord_type b0, size_type blen);
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W:0]   ae;
      logic signed [COORD_W:0]   be;
      logic signed [COORD_W:0]   hi;
      logic signed [COORD_W+1:0] diff;
      lo   = (a0 > b0) ? a0 : b0;
      ae   = $signed({a0[COORD_W-1], a0}) + $signed({2'b00, alen});
      be   = $signed({b0[COORD_W-1], b0}) + $signed({2'b00, blen});
      hi   = (ae < be) ? ae : be;
      diff = $signed({hi[COORD_W], hi}) - $signed({{2{lo[COORD_W-1]}}, lo});
      return (diff > 0) ? diff[SIZE_W-1:0] : '0;
   endfunction

   logic               v1_ff, v1_in;
   size_type           ox_ff, oy_ff, wb_ff, hb_ff;
   logic               v2_ff;
   area_type           inter2_ff, areab_ff;
   logic               v3_ff;
   area_type           inter3_ff;
   logic [UNION_W-1:0] union_ff;
   logic               v4_ff;
   area_type           inter4_ff;
   logic [PROD_W-1:0]  rhs_ff;
   logic [PROD_W-1:0]  lhs;

   assign v1_in = rd_valid && (thr != '0) && (agnostic || (rd_entry.label == cur.label));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff     <= overlap_1d(cur.left, cur.width, rd_entry.left, rd_entry.width);
      oy_ff     <= overlap_1d(cur.top, cur.height, rd_entry.top, rd_entry.height);
      wb_ff     <= rd_entry.width;
      hb_ff     <= rd_entry.height;
      inter2_ff <= ox_ff * oy_ff;
      areab_ff  <= wb_ff * hb_ff;
      inter3_ff <= inter2_ff;
      union_ff  <= {1'b0, area_a} + {1'b0, areab_ff} - {1'b0, inter2_ff};
      inter4_ff <= inter3_ff;
      rhs_ff    <= thr * union_ff;
   end

   assign lhs         = {{(PROD_W-AREA_W-8){1'b0}}, inter4_ff, 8'b0};
   assign status.hit  = v4_ff && (lhs > rhs_ff);
   assign status.busy = v1_ff || v2_ff || v3_ff || v4_ff;

endmodule

// ===== rtl/core/greedy_box_suppression_unit.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// n = boxes kept in the set so far, n <= MAX_KEPT. After a request is accepted,
// the kept-box memory's read port reads one kept box per cycle into the compare
// pipeline; the verdict is registered when the scan and pipeline are done, and a
// stalled verdict holds the scan end. A new request is taken only in idle.
// Reset: kept count cleared, threshold 115, class-aware mode; no memory clear.
// ----------------------------------------------------------------------------
module greedy_box_suppression_unit
   import gbs_pkg::*;
#(
   parameter int MAX_KEPT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   gbs_req_if.sink                req_bus,
   gbs_rsp_if.source              rsp_bus,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic           state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  base_ff, base_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic           rd_valid_ff;
   logic           hit_ff, hit_in;
   kept_entry_type cur_ff;
   area_type       area_a_ff;
   thr_type        thr_ff;
   logic           agnostic_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_keep_ff;
   slot_type       rsp_slot_ff;
   logic           rsp_full_ff;

   logic                  accept;
   logic                  issue;
   logic                  finish;
   logic                  keep;
   logic                  full;
   logic                  store;
   logic [CW+SLOT_W-1:0]  slot_wide;
   kept_entry_type        rd_entry;
   kept_entry_type        req_entry;
   iou_status_type        iou_status;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign req_entry.left   = req_bus.box_left;
   assign req_entry.top    = req_bus.box_top;
   assign req_entry.width  = req_bus.box_width;
   assign req_entry.height = req_bus.box_height;
   assign req_entry.label  = req_bus.class_label;

   assign issue  = (state_ff == ST_SCAN) && (scan_ff < base_ff);
   assign finish = (state_ff == ST_SCAN) && (scan_ff == base_ff) && !rd_valid_ff &&
                   !iou_status.busy && (!rsp_valid_ff || rsp_bus.ready);
   assign keep   = !hit_ff;
   assign full   = keep && (base_ff == CW'(MAX_KEPT));
   assign store  = finish && keep && !full;

   assign base_in   = req_bus.first_of_set ? '0 : count_ff;
   assign slot_wide = {{SLOT_W{1'b0}}, base_ff};

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff || iou_status.hit;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               scan_in  = '0;
               hit_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + CW'(1);
            end
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               count_in     = store ? base_ff + CW'(1) : base_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
         agnostic_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rd_valid_ff  <= issue;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_IOU_THRESHOLD:  thr_ff      <= csr_write_data[THR_W-1:0];
               CSR_CLASS_AGNOSTIC: agnostic_ff <= csr_write_data[0];
               default:            thr_ff      <= thr_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff    <= req_entry;
         base_ff   <= base_in;
         area_a_ff <= req_bus.box_width * req_bus.box_height;
      end
      if (finish) begin
         rsp_keep_ff <= keep;
         rsp_slot_ff <= slot_wide[SLOT_W-1:0];
         rsp_full_ff <= full;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.keep       = rsp_keep_ff;
   assign rsp_bus.kept_slot  = rsp_slot_ff;
   assign rsp_bus.store_full = rsp_full_ff;

   gbs_ram #(
      .WIDTH ($bits(kept_entry_type)),
      .DEPTH (MAX_KEPT)
   ) u_kept_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (base_ff[AW-1:0]),
      .wr_data (cur_ff),
      .rd_en   (issue),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   gbs_iou u_iou (
      .clock    (clock),
      .reset    (reset),
      .rd_valid (rd_valid_ff),
      .rd_entry (rd_entry),
      .cur      (cur_ff),
      .area_a   (area_a_ff),
      .thr      (thr_ff),
      .agnostic (agnostic_ff),
      .status   (iou_status)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEPT))
      else $error("kept count beyond store depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= base_ff))
      else $error("scan index passed kept count");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!rd_valid_ff && !iou_status.busy))
      else $error("request accepted while compare pipeline busy");

   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("verdict not presented after scan end");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      store |-> (base_ff < CW'(MAX_KEPT)))
      else $error("write into full store");
`endif

endmodule
